// File: src/proxy_address_syntax_checker_macros.svh
// Assertion macros shared by the checker RTL.
// In synthesis builds the macros expand to nothing.
`ifndef PROXY_ADDRESS_SYNTAX_CHECKER_MACROS_SVH
`define PROXY_ADDRESS_SYNTAX_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent assertion on a given clock, switched off during reset.
`define PASC_ASSERT_CLK(lbl, clock, rstn, prop, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) prop) else $error(msg);
// The same on the block's own clk and arst_n.
`define PASC_ASSERT(lbl, prop, msg) \
	`PASC_ASSERT_CLK(lbl, clk, arst_n, prop, msg)
`else
`define PASC_ASSERT_CLK(lbl, clock, rstn, prop, msg)
`define PASC_ASSERT(lbl, prop, msg)
`endif
`endif

// File: src/pasc_pkg.sv
`timescale 1ns / 1ps
package pasc_pkg;

	// Character codes used by the parser.
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_COLON = ":";
	localparam logic [7:0] CHAR_SLASH = "/";
	localparam logic [7:0] CHAR_DOT   = ".";
	localparam logic [7:0] CHAR_AT    = "@";
	localparam logic [7:0] CHAR_ZERO  = "0";
	localparam logic [7:0] CHAR_NINE  = "9";

	// Limits of the address syntax.
	localparam int SCHEME_BUFFER_SIZE = 16;
	localparam logic [4:0]  LEN_SAT   = 5'd31;
	localparam logic [11:0] OCTET_MAX = 12'd255;
	localparam logic [19:0] PORT_MAX  = 20'd65535;
	localparam logic [1:0]  DOT_LAST  = 2'd3;
	localparam logic [1:0]  DIGIT_MAX = 2'd3;

	// Separator matcher progress codes.
	localparam logic [1:0] SEP_NONE  = 2'd0;
	localparam logic [1:0] SEP_COLON = 2'd1;
	localparam logic [1:0] SEP_SLASH = 2'd2;

	// Accepted scheme names including the trailing separator.
	localparam int NUM_NAMES = 4;
	localparam logic [7:0] NAME_CHARS [NUM_NAMES][10] = '{
		'{"h", "t", "t", "p", ":", "/", "/", 8'h00, 8'h00, 8'h00},
		'{"h", "t", "t", "p", "s", ":", "/", "/", 8'h00, 8'h00},
		'{"s", "o", "c", "k", "s", "4", ":", "/", "/", 8'h00},
		'{"s", "o", "c", "k", "s", "5", ":", "/", "/", 8'h00}
	};
	localparam logic [4:0] NAME_LEN [NUM_NAMES] = '{5'd7, 5'd8, 5'd9, 5'd9};

	// State of one host and port checker.
	typedef struct packed {
		logic        at_seen;
		logic        in_port;
		logic [7:0]  octet;
		logic [1:0]  digits;
		logic [1:0]  dots;
		logic [15:0] port;
		logic        failed;
	} chk_t;

	localparam chk_t CHK_RESET = '0;

	// One bit per scheme name that still agrees with character c at position pos.
	function automatic logic [NUM_NAMES-1:0] name_hits(input logic [4:0] pos,
			input logic [7:0] c);
		logic [NUM_NAMES-1:0] hits;
		hits = '0;
		for (int k = 0; k < NUM_NAMES; k++) begin
			if (pos < NAME_LEN[k]) begin
				hits[k] = (NAME_CHARS[k][pos[3:0]] == c);
			end
		end
		return hits;
	endfunction

	// One bit per scheme name whose last character sits at position pos.
	function automatic logic [NUM_NAMES-1:0] name_ends(input logic [4:0] pos);
		logic [NUM_NAMES-1:0] ends;
		for (int k = 0; k < NUM_NAMES; k++) begin
			ends[k] = ((pos + 5'd1) == NAME_LEN[k]);
		end
		return ends;
	endfunction

endpackage

// File: src/proxy_address_syntax_checker.sv
`timescale 1ns / 1ps
// Channel   Direction  Beat content
// s_axis    in         s_tdata[7:0] = char_code
// m_axis    out        m_tdata[0] = syntax_ok, m_tdata[7:1] = zero
//
// Every character beat is registered, then folded into the parser state by logic,
// so a character can be taken in every cycle unless a terminator waits on a full result.
// Only a zero character gives a result beat, passed from the input register to the result register.
// While a result waits on m_tready, a new character is still taken into the
// input register; a further zero character then holds the input side.
// Reset (arst_n low) clears the parser state and the valid flags of both beat registers.
`include "proxy_address_syntax_checker_macros.svh"
module proxy_address_syntax_checker #(
	parameter int SCHEME_BUFFER_SIZE = pasc_pkg::SCHEME_BUFFER_SIZE
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] syntax_ok, [7:1] zero
);

	// Input register
	logic       valid_s1;
	logic [7:0] char_s1;

	// Parser state
	logic [4:0]                     len_q;
	logic [pasc_pkg::NUM_NAMES-1:0] match_q;
	logic [1:0]                     sep_q;
	logic                           found_q;
	pasc_pkg::chk_t                 chk_q [2];

	// Result register
	logic m_valid_q;
	logic ok_q;

	logic                           is_end;
	logic                           adv_s1;
	logic [4:0]                     len_d;
	logic [pasc_pkg::NUM_NAMES-1:0] match_d;
	logic [1:0]                     sep_d;
	logic                           found_d;
	pasc_pkg::chk_t                 chk_d [2];
	logic                           ok_d;
	logic [4:0]                     slen;

	// Advance one host and port checker by one character.
	function automatic pasc_pkg::chk_t chk_step(input pasc_pkg::chk_t cur,
			input logic [7:0] c);
		pasc_pkg::chk_t nxt;
		logic           dig;
		logic [11:0]    ov;
		logic [19:0]    pv;
		nxt = cur;
		dig = (c >= pasc_pkg::CHAR_ZERO) && (c <= pasc_pkg::CHAR_NINE);
		ov  = ({4'b0, cur.octet} << 3) + ({4'b0, cur.octet} << 1) + {8'b0, c[3:0]};
		pv  = ({4'b0, cur.port} << 3) + ({4'b0, cur.port} << 1) + {16'b0, c[3:0]};
		if (!cur.at_seen && c == pasc_pkg::CHAR_AT) begin
			// The first '@' ends the user info and restarts the address.
			nxt = pasc_pkg::CHK_RESET;
			nxt.at_seen = 1'b1;
		end else if (!cur.failed) begin
			if (!cur.in_port) begin
				if (dig) begin
					if (cur.digits >= pasc_pkg::DIGIT_MAX || ov > pasc_pkg::OCTET_MAX) begin
						nxt.failed = 1'b1;
					end else begin
						nxt.octet  = ov[7:0];
						nxt.digits = cur.digits + 2'd1;
					end
				end else if (c == pasc_pkg::CHAR_DOT) begin
					if (cur.digits == 2'd0 || cur.dots >= pasc_pkg::DOT_LAST) begin
						nxt.failed = 1'b1;
					end else begin
						nxt.dots   = cur.dots + 2'd1;
						nxt.octet  = 8'd0;
						nxt.digits = 2'd0;
					end
				end else if (c == pasc_pkg::CHAR_COLON) begin
					if (cur.digits == 2'd0 || cur.dots != pasc_pkg::DOT_LAST) begin
						nxt.failed = 1'b1;
					end else begin
						nxt.in_port = 1'b1;
						nxt.port    = 16'd0;
					end
				end else begin
					nxt.failed = 1'b1;
				end
			end else begin
				if (dig && pv <= pasc_pkg::PORT_MAX) begin
					nxt.port = pv[15:0];
				end else begin
					nxt.failed = 1'b1;
				end
			end
		end
		return nxt;
	endfunction

	function automatic logic chk_ok(input pasc_pkg::chk_t cur);
		return !cur.failed && cur.in_port && (cur.port != 16'd0);
	endfunction

	// Handshake: the registered character moves on unless it is a terminator
	// and the result register is still full.
	assign is_end   = (char_s1 == pasc_pkg::CHAR_NUL);
	assign adv_s1   = valid_s1 && (!is_end || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, ok_q};
	assign slen     = len_q - 5'd2;

	// Next parser state and verdict for the registered character.
	always_comb begin
		len_d   = len_q;
		match_d = match_q;
		sep_d   = sep_q;
		found_d = found_q;
		chk_d   = chk_q;
		ok_d    = 1'b0;
		if (is_end) begin
			if (len_q == 5'd0) begin
				ok_d = 1'b0;
			end else if (found_q) begin
				ok_d = (match_q != '0) && chk_ok(chk_q[1]);
			end else begin
				ok_d = chk_ok(chk_q[0]);
			end
			len_d   = 5'd0;
			match_d = '1;
			sep_d   = pasc_pkg::SEP_NONE;
			found_d = 1'b0;
			chk_d   = '{pasc_pkg::CHK_RESET, pasc_pkg::CHK_RESET};
		end else begin
			if (!found_q) begin
				match_d = match_q & pasc_pkg::name_hits(len_q, char_s1);
				if (sep_q == pasc_pkg::SEP_SLASH && char_s1 == pasc_pkg::CHAR_SLASH) begin
					// "://" complete: keep only names that end exactly here.
					found_d = 1'b1;
					sep_d   = pasc_pkg::SEP_NONE;
					if (slen == 5'd0 || 7'(slen) >= 7'(SCHEME_BUFFER_SIZE)) begin
						match_d = '0;
					end else begin
						match_d = match_d & pasc_pkg::name_ends(len_q);
					end
				end else if (char_s1 == pasc_pkg::CHAR_COLON) begin
					sep_d = pasc_pkg::SEP_COLON;
				end else if (sep_q == pasc_pkg::SEP_COLON && char_s1 == pasc_pkg::CHAR_SLASH) begin
					sep_d = pasc_pkg::SEP_SLASH;
				end else begin
					sep_d = pasc_pkg::SEP_NONE;
				end
			end
			if (len_q < pasc_pkg::LEN_SAT) begin
				len_d = len_q + 5'd1;
			end
			chk_d[0] = chk_step(chk_q[0], char_s1);
			if (found_q) begin
				chk_d[1] = chk_step(chk_q[1], char_s1);
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= 5'd0;
			match_q <= '1;
			sep_q   <= pasc_pkg::SEP_NONE;
			found_q <= 1'b0;
			chk_q   <= '{pasc_pkg::CHK_RESET, pasc_pkg::CHK_RESET};
		end else if (adv_s1) begin
			len_q   <= len_d;
			match_q <= match_d;
			sep_q   <= sep_d;
			found_q <= found_d;
			chk_q   <= chk_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1 && is_end) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_end) begin
			ok_q <= ok_d;
		end
	end

	// A new result beat only follows a terminator in the input register.
	`PASC_ASSERT(a_result_from_end,
		$rose(m_valid_q) |-> $past(valid_s1 && is_end), "result beat without terminator")
	// The separator flag only clears when a string ends.
	`PASC_ASSERT(a_found_sticky,
		$fell(found_q) |-> $past(adv_s1 && is_end), "separator flag lost mid string")
	// Once the separator is found its matcher stays idle.
	`PASC_ASSERT(a_sep_idle,
		found_q |-> (sep_q == pasc_pkg::SEP_NONE), "separator matcher active after match")
	// The second checker stays in reset until the separator is found.
	`PASC_ASSERT(a_chk1_idle,
		!found_q |-> (chk_q[1] == pasc_pkg::CHK_RESET), "second checker ran early")
	// An empty string state holds all scheme candidates.
	`PASC_ASSERT(a_empty_state,
		(len_q == 5'd0) |-> (match_q == '1 && !found_q), "empty string with stale scheme")

endmodule
